// ----- rtl/fctt_pkg.sv -----
// Shared types and codes of the frame countdown timer table.
`default_nettype none

package fctt_pkg;

   localparam int ACTION_W   = 2;
   localparam int TIMER_ID_W = 8;
   localparam int FRAMES_W   = 16;
   localparam int KIND_W     = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ARM    = 2'd0,
      ACT_RELOAD = 2'd1,
      ACT_CANCEL = 2'd2,
      ACT_TICK   = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONE      = 3'd0,
      KIND_NOT_FOUND = 3'd1,
      KIND_FULL      = 3'd2,
      KIND_FIRED     = 3'd3,
      KIND_IDLE_TICK = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [TIMER_ID_W-1:0]   fired_id;
      logic                    last;
   } result_type;

   typedef struct packed {
      logic zero;
      logic match;
   } alu_flags_type;

endpackage

`default_nettype wire

// ----- rtl/fctt_req_if.sv -----
// Request channel of the timer table: action, timer id and frame count.
`default_nettype none

interface fctt_req_if;
   logic                              valid;
   logic                              ready;
   logic [fctt_pkg::ACTION_W-1:0]     action;
   logic [fctt_pkg::TIMER_ID_W-1:0]   timer_id;
   logic [fctt_pkg::FRAMES_W-1:0]     frames;

   modport source (output valid, action, timer_id, frames, input ready);
   modport sink   (input valid, action, timer_id, frames, output ready);
endinterface

`default_nettype wire

// ----- rtl/fctt_rsp_if.sv -----
// Response channel of the timer table: result kind, fired id and last flag.
`default_nettype none

interface fctt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [fctt_pkg::KIND_W-1:0]       kind;
   logic [fctt_pkg::TIMER_ID_W-1:0]   fired_id;
   logic                              last;

   modport source (output valid, kind, fired_id, last, input ready);
   modport sink   (input valid, kind, fired_id, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/fctt_alu.sv -----
// Shared unit: count decrement with zero test, and timer key compare.
`default_nettype none

module fctt_alu #(
   parameter int COUNT_WIDTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input  wire logic [COUNT_WIDTH-1:0]  count_val,
   input  wire logic [ID_WIDTH-1:0]     key_a,
   input  wire logic [ID_WIDTH-1:0]     key_b,
   output logic      [COUNT_WIDTH-1:0]  dec_val,
   output fctt_pkg::alu_flags_type      flags
);

   // The decrement wraps, so a count loaded as zero runs the full period.
   assign dec_val     = count_val - 1'b1;
   assign flags.zero  = (dec_val == '0);
   assign flags.match = (key_a == key_b);

endmodule

`default_nettype wire

// ----- rtl/fctt_seq.sv -----
// Sequencer of the timer table: entry memory, fill count and the entry walks.
`default_nettype none

module fctt_seq #(
   parameter int ENTRIES     = 8,
   parameter int COUNT_WIDTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [fctt_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [fctt_pkg::TIMER_ID_W-1:0]   req_timer_id,
   input  wire logic [fctt_pkg::FRAMES_W-1:0]     req_frames,
   output logic                                   res_valid,
   input  wire logic                              res_ready,
   output fctt_pkg::result_type                   res_word
);

   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int KEY_IN_W = (ID_WIDTH < fctt_pkg::TIMER_ID_W) ? ID_WIDTH
                                                               : fctt_pkg::TIMER_ID_W;
   localparam int LOAD_W   = (COUNT_WIDTH < fctt_pkg::FRAMES_W) ? COUNT_WIDTH
                                                                : fctt_pkg::FRAMES_W;
   localparam int WORD_W   = ID_WIDTH + COUNT_WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_DECIDE,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_NEW,
      ST_TICK_RD,
      ST_TICK_PROC,
      ST_TICK_END,
      ST_RESP
   } state_type;

   // Entries are kept packed in age order: position 0 is the newest timer,
   // and positions at or above the fill count hold nothing.
   logic [WORD_W-1:0] entry_mem [ENTRIES];
   logic [WORD_W-1:0] rd_word_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [IDX_W-1:0]  wr_addr;
   logic [CNT_W-1:0]  wr_pos;
   logic [WORD_W-1:0] wr_word;
   logic              mem_we;

   state_type            state_ff,    state_in;
   fctt_pkg::action_type action_ff,   action_in;
   fctt_pkg::kind_type   kind_ff,     kind_in;
   logic [ID_WIDTH-1:0]    key_ff,      key_in;
   logic [COUNT_WIDTH-1:0] load_ff,     load_in;
   logic [CNT_W-1:0]       fill_ff,     fill_in;
   logic [CNT_W-1:0]       idx_ff,      idx_in;
   logic [CNT_W-1:0]       wpos_ff,     wpos_in;
   logic                   found_ff,    found_in;
   logic                   pend_ff,     pend_in;
   logic [ID_WIDTH-1:0]    pend_key_ff, pend_key_in;

   logic [ID_WIDTH-1:0]     rd_key;
   logic [COUNT_WIDTH-1:0]  rd_count;
   logic [COUNT_WIDTH-1:0]  dec_val;
   fctt_pkg::alu_flags_type flags;
   logic [CNT_W-1:0]        idx_next;
   logic [CNT_W-1:0]        idx_prev;
   logic                    advance;

   assign rd_key   = rd_word_ff[WORD_W-1:COUNT_WIDTH];
   assign rd_count = rd_word_ff[COUNT_WIDTH-1:0];
   assign idx_next = idx_ff + 1'b1;
   assign idx_prev = idx_ff - 1'b1;
   assign wr_addr  = wr_pos[IDX_W-1:0];

   fctt_alu #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_alu (
      .count_val (rd_count),
      .key_a     (rd_key),
      .key_b     (key_ff),
      .dec_val   (dec_val),
      .flags     (flags)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[wr_addr] <= wr_word;
      end
      rd_word_ff <= entry_mem[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      load_in     = load_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      wpos_in     = wpos_ff;
      found_in    = found_ff;
      pend_in     = pend_ff;
      pend_key_in = pend_key_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res_word    = '{kind: fctt_pkg::KIND_DONE, fired_id: '0, last: 1'b1};
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_pos      = wpos_ff;
      wr_word     = rd_word_ff;
      mem_we      = 1'b0;
      advance     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               action_in = fctt_pkg::action_type'(req_action);
               key_in    = ID_WIDTH'(req_timer_id[KEY_IN_W-1:0]);
               load_in   = COUNT_WIDTH'(req_frames[LOAD_W-1:0]);
               idx_in    = '0;
               wpos_in   = '0;
               found_in  = 1'b0;
               pend_in   = 1'b0;
               if (fctt_pkg::action_type'(req_action) == fctt_pkg::ACT_TICK) begin
                  state_in = (fill_ff == '0) ? ST_TICK_END : ST_TICK_RD;
               end else begin
                  state_in = (fill_ff == '0) ? ST_DECIDE : ST_SRCH_RD;
               end
            end
         end

         ST_SRCH_RD: begin
            state_in = ST_SRCH_CHK;
         end

         ST_SRCH_CHK: begin
            if (flags.match) begin
               found_in = 1'b1;
               state_in = ST_DECIDE;
            end else if (idx_next == fill_ff) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_next;
               state_in = ST_SRCH_RD;
            end
         end

         ST_DECIDE: begin
            if (found_ff) begin
               if (action_ff == fctt_pkg::ACT_CANCEL) begin
                  idx_in   = idx_next;
                  state_in = ST_DEL_RD;
               end else begin
                  mem_we   = 1'b1;
                  wr_pos   = idx_ff;
                  wr_word  = {key_ff, load_ff};
                  kind_in  = fctt_pkg::KIND_DONE;
                  state_in = ST_RESP;
               end
            end else if (action_ff == fctt_pkg::ACT_ARM) begin
               if (fill_ff == CNT_W'(ENTRIES)) begin
                  kind_in  = fctt_pkg::KIND_FULL;
                  state_in = ST_RESP;
               end else begin
                  idx_in   = fill_ff;
                  state_in = ST_INS_RD;
               end
            end else begin
               kind_in  = fctt_pkg::KIND_NOT_FOUND;
               state_in = ST_RESP;
            end
         end

         // Removal closes the gap: every older entry behind it moves
         // up one place.
         ST_DEL_RD: begin
            if (idx_ff == fill_ff) begin
               fill_in  = fill_ff - 1'b1;
               kind_in  = fctt_pkg::KIND_DONE;
               state_in = ST_RESP;
            end else begin
               state_in = ST_DEL_WR;
            end
         end

         ST_DEL_WR: begin
            mem_we   = 1'b1;
            wr_pos   = idx_prev;
            idx_in   = idx_next;
            state_in = ST_DEL_RD;
         end

         // Insertion shifts every entry down one place, from the oldest end,
         // and then writes the new timer at the head.
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = ST_INS_NEW;
            end else begin
               rd_addr  = idx_prev[IDX_W-1:0];
               idx_in   = idx_prev;
               state_in = ST_INS_WR;
            end
         end

         ST_INS_WR: begin
            mem_we   = 1'b1;
            wr_pos   = idx_next;
            state_in = ST_INS_RD;
         end

         ST_INS_NEW: begin
            mem_we   = 1'b1;
            wr_pos   = '0;
            wr_word  = {key_ff, load_ff};
            fill_in  = fill_ff + 1'b1;
            kind_in  = fctt_pkg::KIND_DONE;
            state_in = ST_RESP;
         end

         ST_TICK_RD: begin
            state_in = ST_TICK_PROC;
         end

         // One fired word is held back so that the final one can carry last.
         // Survivors are written back compacted, keeping their order.
         ST_TICK_PROC: begin
            if (flags.zero && pend_ff) begin
               res_valid = 1'b1;
               res_word  = '{kind: fctt_pkg::KIND_FIRED,
                             fired_id: fctt_pkg::TIMER_ID_W'(pend_key_ff),
                             last: 1'b0};
               advance   = res_ready;
            end else begin
               advance = 1'b1;
            end
            if (advance) begin
               if (flags.zero) begin
                  pend_in     = 1'b1;
                  pend_key_in = rd_key;
               end else begin
                  mem_we  = 1'b1;
                  wr_pos  = wpos_ff;
                  wr_word = {rd_key, dec_val};
                  wpos_in = wpos_ff + 1'b1;
               end
               idx_in   = idx_next;
               state_in = (idx_next == fill_ff) ? ST_TICK_END : ST_TICK_RD;
            end
         end

         ST_TICK_END: begin
            res_valid = 1'b1;
            if (pend_ff) begin
               res_word = '{kind: fctt_pkg::KIND_FIRED,
                            fired_id: fctt_pkg::TIMER_ID_W'(pend_key_ff),
                            last: 1'b1};
            end else begin
               res_word = '{kind: fctt_pkg::KIND_IDLE_TICK, fired_id: '0, last: 1'b1};
            end
            if (res_ready) begin
               fill_in  = wpos_ff;
               state_in = ST_IDLE;
            end
         end

         ST_RESP: begin
            res_valid = 1'b1;
            res_word  = '{kind: kind_ff, fired_id: '0, last: 1'b1};
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
      end
      action_ff   <= action_in;
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      load_ff     <= load_in;
      idx_ff      <= idx_in;
      wpos_ff     <= wpos_in;
      pend_key_ff <= pend_key_in;
   end

endmodule

`default_nettype wire

// ----- rtl/frame_countdown_timer_table.sv -----
// Top level of the frame countdown timer table, with the response register.
//
//   channel   direction   words
//   req_ch    in          action, timer_id, frames
//   rsp_ch    out         kind, fired_id, last
//
// One request is worked on at a time; req_ch.ready is low until its last
// response word has been handed to the output register.
// A search walks the entries one at a time through the single memory read
// port, in a read and a check state each; arm and cancel then shift entries.
// A tick walks every held entry in a read and a process state each.
// Reset empties the table at once through the fill count; no clearing pass.
// A stalled response holds the sequencer, the output register keeps its word.
`default_nettype none

module frame_countdown_timer_table #(
   parameter int ENTRIES     = 8,
   parameter int COUNT_WIDTH = 16,
   parameter int ID_WIDTH    = 8
) (
   input wire logic       clock,
   input wire logic       reset,
   fctt_req_if.sink       req_ch,
   fctt_rsp_if.source     rsp_ch
);

   logic                 res_valid;
   logic                 res_ready;
   fctt_pkg::result_type res_word;

   logic                 out_valid_ff, out_valid_in;
   fctt_pkg::result_type out_word_ff,  out_word_in;

   fctt_seq #(
      .ENTRIES     (ENTRIES),
      .COUNT_WIDTH (COUNT_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_ready    (req_ch.ready),
      .req_action   (req_ch.action),
      .req_timer_id (req_ch.timer_id),
      .req_frames   (req_ch.frames),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_word     (res_word)
   );

   // The register takes a new word whenever it is empty or being drained.
   assign res_ready = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (res_ready) begin
         out_valid_in = res_valid;
         if (res_valid) begin
            out_word_in = res_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.kind     = out_word_ff.kind;
   assign rsp_ch.fired_id = out_word_ff.fired_id;
   assign rsp_ch.last     = out_word_ff.last;

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while the previous one was still in progress");

   a_id_only_when_fired: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.kind != fctt_pkg::KIND_FIRED) |-> rsp_ch.fired_id == '0)
      else $error("fired_id set on a word that reports no expiry");

   a_idle_tick_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.kind == fctt_pkg::KIND_IDLE_TICK) |-> rsp_ch.last)
      else $error("quiet tick word not flagged as last");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_frame_countdown_timer_table.sv -----
// Self-checking testbench of the frame countdown timer table, with its result predictor.
`default_nettype none

module tb_frame_countdown_timer_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH     = 8;
   localparam int RANDOM_ITEMS    = 345;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 30;

   // Mirrors the table and keeps the result words still owed by the block.
   class timer_predictor;
      bit                              entry_used [TABLE_DEPTH];
      logic [fctt_pkg::TIMER_ID_W-1:0] entry_id   [TABLE_DEPTH];
      logic [fctt_pkg::FRAMES_W-1:0]   entry_left [TABLE_DEPTH];
      int                              entry_rank [TABLE_DEPTH];
      fctt_pkg::result_type            pending_results [$];
      int                              mismatches;

      function void push_result(fctt_pkg::kind_type kind,
                                logic [fctt_pkg::TIMER_ID_W-1:0] id, logic last);
         fctt_pkg::result_type word;
         word.kind     = kind;
         word.fired_id = id;
         word.last     = last;
         pending_results.push_back(word);
      endfunction

      function int find_id(logic [fctt_pkg::TIMER_ID_W-1:0] id);
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (entry_used[i] && entry_id[i] == id) return i;
         end
         return -1;
      endfunction

      // Closes the gaps in the age ranks after entries have been removed.
      function void compact_ranks();
         int fresh [TABLE_DEPTH];
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            fresh[i] = 0;
            for (int j = 0; j < TABLE_DEPTH; j++) begin
               if (entry_used[i] && entry_used[j] && entry_rank[j] < entry_rank[i]) fresh[i]++;
            end
         end
         for (int i = 0; i < TABLE_DEPTH; i++) entry_rank[i] = fresh[i];
      endfunction

      function void note_request(fctt_pkg::action_type act,
                                 logic [fctt_pkg::TIMER_ID_W-1:0] id,
                                 logic [fctt_pkg::FRAMES_W-1:0] frames);
         bit expired [TABLE_DEPTH];
         int total;
         int emitted;
         int slot;
         int free_slot;
         if (act == fctt_pkg::ACT_TICK) begin
            total = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               expired[i] = 1'b0;
               if (entry_used[i]) begin
                  entry_left[i] = entry_left[i] - 1'b1;
                  expired[i]    = (entry_left[i] == '0);
                  if (expired[i]) total++;
               end
            end
            if (total == 0) begin
               push_result(fctt_pkg::KIND_IDLE_TICK, '0, 1'b1);
               return;
            end
            emitted = 0;
            for (int r = 0; r < TABLE_DEPTH; r++) begin
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (entry_used[i] && expired[i] && entry_rank[i] == r) begin
                     push_result(fctt_pkg::KIND_FIRED, entry_id[i], emitted == total - 1);
                     emitted++;
                  end
               end
            end
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (expired[i]) entry_used[i] = 1'b0;
            end
            compact_ranks();
            return;
         end
         slot = find_id(id);
         if (act == fctt_pkg::ACT_CANCEL) begin
            if (slot < 0) begin
               push_result(fctt_pkg::KIND_NOT_FOUND, '0, 1'b1);
            end else begin
               entry_used[slot] = 1'b0;
               compact_ranks();
               push_result(fctt_pkg::KIND_DONE, '0, 1'b1);
            end
            return;
         end
         if (slot >= 0) begin
            entry_left[slot] = frames;
            push_result(fctt_pkg::KIND_DONE, '0, 1'b1);
            return;
         end
         if (act == fctt_pkg::ACT_RELOAD) begin
            push_result(fctt_pkg::KIND_NOT_FOUND, '0, 1'b1);
            return;
         end
         free_slot = -1;
         for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!entry_used[i]) free_slot = i;
         end
         if (free_slot < 0) begin
            push_result(fctt_pkg::KIND_FULL, '0, 1'b1);
            return;
         end
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (entry_used[i]) entry_rank[i]++;
         end
         entry_used[free_slot] = 1'b1;
         entry_id[free_slot]   = id;
         entry_left[free_slot] = frames;
         entry_rank[free_slot] = 0;
         push_result(fctt_pkg::KIND_DONE, '0, 1'b1);
      endfunction

      function void check_result(logic [fctt_pkg::KIND_W-1:0] kind,
                                 logic [fctt_pkg::TIMER_ID_W-1:0] fired_id, logic last);
         fctt_pkg::result_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: kind %0d, fired_id %0d, last %0d",
                   kind, fired_id, last);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (want.kind !== kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatches++;
         end
         if (want.fired_id !== fired_id) begin
            $error("fired_id: expected %0d, got %0d", want.fired_id, fired_id);
            mismatches++;
         end
         if (want.last !== last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   bit   hold_request = 1'b0;
   int   idle_cycles = 0;

   timer_predictor predictor = new;

   fctt_req_if req_ch ();
   fctt_rsp_if rsp_ch ();

   frame_countdown_timer_table #(
      .ENTRIES     (TABLE_DEPTH),
      .COUNT_WIDTH (fctt_pkg::FRAMES_W),
      .ID_WIDTH    (fctt_pkg::TIMER_ID_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one word and waits for it to be taken. Valid stays high only when
   // another word follows at once.
   task automatic send_request(fctt_pkg::action_type act,
                               logic [fctt_pkg::TIMER_ID_W-1:0] id,
                               logic [fctt_pkg::FRAMES_W-1:0] frames, bit another);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.timer_id <= id;
      req_ch.frames   <= frames;
      do @(posedge clock); while (!req_ch.ready);
      predictor.note_request(act, id, frames);
      gap = pick_gap();
      if (gap > 0 || !another) req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      while (predictor.pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("tb_frame_countdown_timer_table failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            predictor.check_result(rsp_ch.kind, rsp_ch.fired_id, rsp_ch.last);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : req_side
      int                              roll;
      fctt_pkg::action_type            act;
      logic [fctt_pkg::TIMER_ID_W-1:0] id;
      logic [fctt_pkg::FRAMES_W-1:0]   frames;
      bit                              another;
      req_ch.valid    <= 1'b0;
      req_ch.action   <= fctt_pkg::ACT_ARM;
      req_ch.timer_id <= '0;
      req_ch.frames   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: a tick fires nothing, lookups miss.
      send_request(fctt_pkg::ACT_TICK,   8'h00, 16'h0000, 1'b1);
      send_request(fctt_pkg::ACT_CANCEL, 8'h00, 16'hFFFF, 1'b1);
      send_request(fctt_pkg::ACT_RELOAD, 8'hFF, 16'h0000, 1'b1);
      // A load of zero wraps to the full period and stays put.
      send_request(fctt_pkg::ACT_ARM,    8'h00, 16'h0000, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'hFF, 16'hFFFF, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'hA5, 16'h0001, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'h5A, 16'h0002, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'h01, 16'h0001, 1'b1);
      // Two timers expire together and come out newest first.
      send_request(fctt_pkg::ACT_TICK,   8'h3C, 16'h1234, 1'b1);
      send_request(fctt_pkg::ACT_RELOAD, 8'h5A, 16'h0003, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'hFF, 16'h0001, 1'b1);
      send_request(fctt_pkg::ACT_TICK,   8'h00, 16'h0000, 1'b1);
      for (int i = 0; i < 6; i++) begin
         send_request(fctt_pkg::ACT_ARM, fctt_pkg::TIMER_ID_W'(8'h10 + i), 16'h0001, 1'b1);
      end
      // The table is full now, so this arm is refused.
      send_request(fctt_pkg::ACT_ARM,    8'h20, 16'h0001, 1'b1);
      send_request(fctt_pkg::ACT_RELOAD, 8'h00, 16'h0001, 1'b1);
      send_request(fctt_pkg::ACT_RELOAD, 8'h5A, 16'h0001, 1'b1);
      // Every entry expires on one tick.
      send_request(fctt_pkg::ACT_TICK,   8'h00, 16'h0000, 1'b1);
      send_request(fctt_pkg::ACT_ARM,    8'h33, 16'h0007, 1'b1);
      send_request(fctt_pkg::ACT_CANCEL, 8'h33, 16'h0000, 1'b1);
      send_request(fctt_pkg::ACT_TICK,   8'h00, 16'h0000, 1'b0);
      wait_for_drain();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         quiet = ((k / 50) % 3 == 1);
         roll  = $urandom_range(0, 99);
         if (roll < 38)      act = fctt_pkg::ACT_TICK;
         else if (roll < 68) act = fctt_pkg::ACT_ARM;
         else if (roll < 82) act = fctt_pkg::ACT_RELOAD;
         else                act = fctt_pkg::ACT_CANCEL;
         roll = $urandom_range(0, 99);
         if (roll < 75)      frames = fctt_pkg::FRAMES_W'($urandom_range(1, 6));
         else if (roll < 85) frames = '0;
         else                frames = fctt_pkg::FRAMES_W'($urandom_range(0, 65535));
         // Long-lived timers take ids from the small set so that cancels can reach them.
         if ($urandom_range(0, 3) == 0 && frames != '0 && frames <= 6) begin
            id = fctt_pkg::TIMER_ID_W'($urandom_range(0, 255));
         end else begin
            id = fctt_pkg::TIMER_ID_W'($urandom_range(0, 15) * 17);
         end
         if (k == 100) hold_request = 1'b1;
         another = (k != RANDOM_ITEMS - 1) && (k != 200);
         send_request(act, id, frames, another);
         if (k == 200) wait_for_drain();
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predictor.pending_results.size() != 0) begin
         $error("%0d result words never arrived", predictor.pending_results.size());
         predictor.mismatches++;
      end
      if (predictor.mismatches == 0) begin
         $display("tb_frame_countdown_timer_table passed");
      end else begin
         $display("tb_frame_countdown_timer_table failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/fctt_pkg.sv
rtl/fctt_req_if.sv
rtl/fctt_rsp_if.sv
rtl/fctt_alu.sv
rtl/fctt_seq.sv
rtl/frame_countdown_timer_table.sv
tb/tb_frame_countdown_timer_table.sv
